[design/hsai_pkg.sv]
// Shared types, constants and helper functions for the hall sector angle interpolator.
// Used by hsai_div and hall_sector_angle_interpolator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hsai_pkg;

  localparam int NUM_SECTORS = 6;
  localparam int SECTOR_W    = 3;

  localparam logic [SECTOR_W-1:0] NO_SECTOR  = 3'd6;
  localparam logic [SECTOR_W-1:0] HALL_BAD   = 3'd7;
  localparam logic [SECTOR_W-1:0] LAST_SECTOR = 3'd5;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  localparam logic [15:0] SPAN        = 16'd10923;
  localparam logic [31:0] SPEED_NUM   = 32'd2796288;   // SPAN << 8
  localparam logic [15:0] TRAVEL_LIM  = 16'd10922;     // SPAN - 1
  localparam logic [15:0] STALL_RESET = 16'd2000;
  localparam logic [15:0] HALF_TURN   = 16'h8000;
  localparam logic [15:0] SAT16       = 16'hFFFF;

  // configuration register indexes
  localparam logic [2:0] REG_ANGLE_OFFSET = 3'd0;
  localparam logic [2:0] REG_STALL_LIMIT  = 3'd1;
  localparam logic [2:0] REG_TRIM0        = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_ENTER,
    ST_RD_LEAVE,
    ST_MUL,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_SPEED_GO,
    ST_SPEED_WAIT,
    ST_EXTRAP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // hall A,B,C -> sector; 0 and 7 are not legal patterns
  function automatic logic [SECTOR_W-1:0] hall_to_sector(input logic [2:0] code);
    logic [SECTOR_W-1:0] s;
    unique case (code)
      3'd1:    s = 3'd3;
      3'd2:    s = 3'd1;
      3'd3:    s = 3'd2;
      3'd4:    s = 3'd5;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd0;
      default: s = HALL_BAD;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] base_anchor(input logic [SECTOR_W-1:0] s);
    logic [15:0] a;
    unique case (s)
      3'd1:    a = 16'd10923;
      3'd2:    a = 16'd21845;
      3'd3:    a = 16'd32768;
      3'd4:    a = 16'd43691;
      3'd5:    a = 16'd54613;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  function automatic logic [SECTOR_W-1:0] next_sector(input logic [SECTOR_W-1:0] s);
    return (s == LAST_SECTOR) ? 3'd0 : s + 3'd1;
  endfunction

endpackage

`default_nettype wire

[design/hsai_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module hsai_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/hsai_div.sv]
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
// Depends on hsai_pkg (div_req_t, div_rsp_t).
`timescale 1ns / 1ps
`default_nettype none

module hsai_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hsai_pkg::div_req_t req,
  output hsai_pkg::div_rsp_t     rsp
);

  localparam int QW = 32;

  logic [16:0]  rem;
  logic [QW-1:0] quo;
  logic [15:0]  dsr;
  logic [5:0]   cnt;
  logic         busy;
  logic         done;
  logic [16:0]  trial;
  logic         fits;

  assign trial = {rem[15:0], quo[QW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(QW);
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= fits ? (trial - {1'b0, dsr}) : trial;
        quo <= {quo[QW-2:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // remainder stays below the divisor while iterating
  assert property (@(posedge clk) disable iff (rst) busy |-> rem < {1'b0, dsr})
    else $error("divider remainder out of range");

  assert property (@(posedge clk) disable iff (rst) done |-> !busy && $past(busy))
    else $error("divider done without a finished run");

  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

[design/hall_sector_angle_interpolator.sv]
// Top level of the hall sector angle interpolator: sequencer, state, shared multiplier.
// Depends on hsai_pkg, hsai_ram (per-sector tick memory) and hsai_div (shared divider).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata[2:0]  hall_code
// m_*       out  m_tvalid/m_tready    m_tdata       result fields, see port comment
// cfg_*     in   cfg_we (no stall)    cfg_index, cfg_data
//
// One request in flight at a time; s_tready is high only while the sequencer idles.
// Paths per request: an invalid code, an untracked or stalled tick, or a first or skipped
// edge goes straight to FINISH; extrapolation passes through MUL and EXTRAP; an adjacent
// edge runs the 32-step divider once with no usable tick memory, twice with memory scaling.
// A finished result waits in the m_tdata register; the sequencer holds in its last
// state until that register is free. Reset (rst, synchronous) restores the tracked state.
module hall_sector_angle_interpolator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,    // [2:0] hall_code
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [15:0] angle, [38:16] speed, [39] angle_valid, [42:40] current_sector,
  // [44:43] direction, [60:45] edge_error, [76:61] bad_edge_count,
  // [92:77] edge_count, [108:93] sector_ticks
  output logic [111:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  localparam int SW = hsai_pkg::SECTOR_W;
  localparam int NS = hsai_pkg::NUM_SECTORS;

  // configuration
  logic [15:0] angle_offset;
  logic [15:0] stall_limit;
  logic [15:0] trim [NS];

  // tracked state
  logic [15:0]        angle_reg;
  logic signed [22:0] speed_reg;
  logic [15:0]        tick_counter;
  logic [SW-1:0]      sector_reg;
  logic [1:0]         direction_reg;
  logic               valid_reg;
  logic [15:0]        edge_error_reg;
  logic [15:0]        skips_reg;
  logic [15:0]        edges_reg;
  logic [NS-1:0]      dur_valid;    // tick memory entries written since reset

  // per-request working registers
  hsai_pkg::state_t   state, state_next;
  logic [SW-1:0]      in_sector;
  logic               is_edge;
  logic [1:0]         pend_dir;
  logic [15:0]        pend_angle;
  logic [15:0]        dur_s;
  logic [15:0]        dur_p;
  logic [15:0]        pred;
  logic signed [40:0] prod;

  // shared units
  hsai_pkg::div_req_t div_req;
  hsai_pkg::div_rsp_t div_rsp;
  logic               ram_we;
  logic [SW-1:0]      ram_raddr;
  logic [15:0]        ram_rdata;

  // decode helpers
  logic          code_bad, is_change, first_seen, fwd, bwd, stalled;
  logic [15:0]   tick_inc;
  logic [SW-1:0] anc_idx, anc_sel;
  logic [15:0]   anchor;
  logic [15:0]   jump, jump_abs;
  logic [15:0]   dur_leave;
  logic [31:0]   scaled;
  logic [15:0]   scaled_sat;
  logic [22:0]   q23;
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] travel_full;
  logic [15:0]   travel;

  assign code_bad   = in_sector == hsai_pkg::HALL_BAD;
  assign is_change  = in_sector != sector_reg;
  assign first_seen = sector_reg == hsai_pkg::NO_SECTOR;
  assign fwd        = in_sector == hsai_pkg::next_sector(sector_reg);
  assign bwd        = sector_reg == hsai_pkg::next_sector(in_sector);
  assign tick_inc   = (tick_counter != hsai_pkg::SAT16) ? tick_counter + 16'd1 : tick_counter;
  assign stalled    = tick_inc > stall_limit;

  // anchor = base + trim + offset, mod one turn
  assign anc_sel = (anc_idx < SW'(NS)) ? anc_idx : '0;
  assign anchor  = hsai_pkg::base_anchor(anc_sel) + trim[anc_sel] + angle_offset;

  assign jump     = angle_reg - anchor;
  assign jump_abs = (jump > hsai_pkg::HALF_TURN) ? (16'd0 - jump) : jump;

  assign dur_leave = dur_valid[sector_reg] ? ram_rdata : 16'd0;

  assign scaled     = div_rsp.quotient;
  assign scaled_sat = (scaled == 32'd0) ? 16'd1 :
                      (scaled > {16'd0, hsai_pkg::SAT16}) ? hsai_pkg::SAT16 : scaled[15:0];
  assign q23        = div_rsp.quotient[22:0];

  // one multiplier: tick memory times measurement, or speed times ticks
  assign mul_a = is_edge ? {8'd0, dur_s} : {speed_reg[22], speed_reg};
  assign mul_b = {1'b0, tick_counter};

  // floor(prod / 256), clamped short of the next anchor
  assign travel_full = prod >>> 8;
  always_comb begin
    if (travel_full > $signed({25'd0, hsai_pkg::TRAVEL_LIM})) begin
      travel = hsai_pkg::TRAVEL_LIM;
    end else if (travel_full < -$signed({25'd0, hsai_pkg::TRAVEL_LIM})) begin
      travel = 16'd0 - hsai_pkg::TRAVEL_LIM;
    end else begin
      travel = travel_full[15:0];
    end
  end

  hsai_ram #(
    .WIDTH(16),
    .DEPTH(NS)
  ) u_dur_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sector_reg),
    .wdata(tick_counter),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hsai_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsai_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_req    = '0;
    ram_we     = 1'b0;
    ram_raddr  = in_sector;
    anc_idx    = in_sector;
    unique case (state)
      hsai_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = hsai_pkg::ST_DECODE;
      end
      hsai_pkg::ST_DECODE: begin
        if (!is_change || (!first_seen && bwd)) anc_idx = sector_reg;
        if (code_bad) begin
          state_next = hsai_pkg::ST_FINISH;
        end else if (is_change) begin
          state_next = (first_seen || !(fwd || bwd)) ? hsai_pkg::ST_FINISH
                                                     : hsai_pkg::ST_RD_ENTER;
        end else if (!stalled && valid_reg && direction_reg != hsai_pkg::DIR_NONE) begin
          state_next = hsai_pkg::ST_MUL;
        end else begin
          state_next = hsai_pkg::ST_FINISH;
        end
      end
      hsai_pkg::ST_RD_ENTER: begin
        ram_raddr  = sector_reg;
        state_next = hsai_pkg::ST_RD_LEAVE;
      end
      hsai_pkg::ST_RD_LEAVE: begin
        ram_we     = 1'b1;
        state_next = (dur_s != 16'd0 && dur_leave != 16'd0 && tick_counter != 16'd0)
                     ? hsai_pkg::ST_MUL : hsai_pkg::ST_SPEED_GO;
      end
      hsai_pkg::ST_MUL: begin
        state_next = is_edge ? hsai_pkg::ST_SCALE_GO : hsai_pkg::ST_EXTRAP;
      end
      hsai_pkg::ST_SCALE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[31:0];
        div_req.divisor  = dur_p;
        state_next       = hsai_pkg::ST_SCALE_WAIT;
      end
      hsai_pkg::ST_SCALE_WAIT: begin
        if (div_rsp.done) state_next = hsai_pkg::ST_SPEED_GO;
      end
      hsai_pkg::ST_SPEED_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = hsai_pkg::SPEED_NUM;
        div_req.divisor  = pred;
        state_next       = hsai_pkg::ST_SPEED_WAIT;
      end
      hsai_pkg::ST_SPEED_WAIT: begin
        if (div_rsp.done) state_next = hsai_pkg::ST_FINISH;
      end
      hsai_pkg::ST_EXTRAP: begin
        // backward travel is measured from the far boundary of the sector
        anc_idx    = (direction_reg == hsai_pkg::DIR_FWD) ? sector_reg
                                                          : hsai_pkg::next_sector(sector_reg);
        state_next = hsai_pkg::ST_FINISH;
      end
      hsai_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) state_next = hsai_pkg::ST_IDLE;
      end
      default: state_next = hsai_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset   <= '0;
      stall_limit    <= hsai_pkg::STALL_RESET;
      for (int i = 0; i < NS; i++) trim[i] <= '0;
      angle_reg      <= '0;
      speed_reg      <= '0;
      tick_counter   <= '0;
      sector_reg     <= hsai_pkg::NO_SECTOR;
      direction_reg  <= hsai_pkg::DIR_NONE;
      valid_reg      <= 1'b0;
      edge_error_reg <= '0;
      skips_reg      <= '0;
      edges_reg      <= '0;
      dur_valid      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hsai_pkg::REG_ANGLE_OFFSET: angle_offset <= cfg_data;
          hsai_pkg::REG_STALL_LIMIT:  stall_limit  <= cfg_data;
          default:                    trim[cfg_index - hsai_pkg::REG_TRIM0] <= cfg_data;
        endcase
      end

      // FINISH reloads the register itself when it is free
      if (m_tvalid && m_tready && state != hsai_pkg::ST_FINISH) m_tvalid <= 1'b0;

      unique case (state)
        hsai_pkg::ST_IDLE: begin
          if (s_tvalid) in_sector <= hsai_pkg::hall_to_sector(s_tdata[2:0]);
        end
        hsai_pkg::ST_DECODE: begin
          is_edge <= is_change;
          if (code_bad) begin
            valid_reg <= 1'b0;
          end else if (is_change) begin
            edges_reg <= edges_reg + 16'd1;
            if (first_seen || !(fwd || bwd)) begin
              // resync to the entered sector
              sector_reg   <= in_sector;
              angle_reg    <= anchor;
              tick_counter <= '0;
              speed_reg    <= '0;
              if (!first_seen) begin
                skips_reg     <= skips_reg + 16'd1;
                direction_reg <= hsai_pkg::DIR_NONE;
              end
            end else begin
              pend_dir       <= fwd ? hsai_pkg::DIR_FWD : hsai_pkg::DIR_REV;
              pend_angle     <= anchor;
              edge_error_reg <= jump_abs;
            end
          end else begin
            tick_counter <= tick_inc;
            if (stalled) begin
              valid_reg <= 1'b0;
              speed_reg <= '0;
            end else if (valid_reg && direction_reg == hsai_pkg::DIR_NONE) begin
              angle_reg <= anchor;
            end
          end
        end
        hsai_pkg::ST_RD_ENTER: begin
          dur_s <= dur_valid[in_sector] ? ram_rdata : 16'd0;
        end
        hsai_pkg::ST_RD_LEAVE: begin
          dur_p                 <= dur_leave;
          dur_valid[sector_reg] <= 1'b1;
          pred                  <= (tick_counter != 16'd0) ? tick_counter : 16'd1;
        end
        hsai_pkg::ST_MUL: begin
          prod <= mul_a * mul_b;
        end
        hsai_pkg::ST_SCALE_GO: begin
        end
        hsai_pkg::ST_SCALE_WAIT: begin
          if (div_rsp.done) pred <= scaled_sat;
        end
        hsai_pkg::ST_SPEED_GO: begin
        end
        hsai_pkg::ST_SPEED_WAIT: begin
          if (div_rsp.done) begin
            speed_reg     <= (pend_dir == hsai_pkg::DIR_REV) ? -$signed(q23) : $signed(q23);
            direction_reg <= pend_dir;
            sector_reg    <= in_sector;
            angle_reg     <= pend_angle;
            tick_counter  <= '0;
            valid_reg     <= 1'b1;
          end
        end
        hsai_pkg::ST_EXTRAP: begin
          angle_reg <= anchor + travel;
        end
        hsai_pkg::ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'd0, tick_counter, edges_reg, skips_reg, edge_error_reg,
                         direction_reg, sector_reg, valid_reg, speed_reg, angle_reg};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a tracked angle always belongs to a real sector
  assert property (@(posedge clk) disable iff (rst) valid_reg |-> sector_reg < 3'(NS))
    else $error("angle valid without a sector");

  // tick memory is only written for the sector being left
  assert property (@(posedge clk) disable iff (rst) ram_we |-> sector_reg < 3'(NS))
    else $error("tick memory write with no sector");

  assert property (@(posedge clk) disable iff (rst)
      div_rsp.done |-> (state == hsai_pkg::ST_SCALE_WAIT || state == hsai_pkg::ST_SPEED_WAIT))
    else $error("divider finished outside a wait state");

  assert property (@(posedge clk) disable iff (rst)
      direction_reg == hsai_pkg::DIR_NONE && sector_reg != hsai_pkg::NO_SECTOR
      |-> speed_reg == 23'sd0)
    else $error("speed nonzero with unknown direction");

  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

endmodule

`default_nettype wire
